### rtl/core/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg: shared constants for the matrix multiply engine
// element, accumulator and configuration widths, register reset values, item actions, register indexes
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  localparam int MAX_DIM_DEF = 16;

  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;

  localparam int CFG_DIM_W  = 5;
  localparam int CFG_CNT_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CNT_W      = 12;
  localparam int MAX_COUNT  = 4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_MATRIX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT     = 2'd3;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] RST_INNER_DIM       = 5'd16;
  localparam logic [CFG_DIM_W-1:0] RST_OUT_COLS        = 5'd16;
  localparam logic [CFG_CNT_W-1:0] RST_ROWS_PER_MATRIX = 13'd16;
  localparam logic [CFG_CNT_W-1:0] RST_BATCH_COUNT     = 13'd1;

  // item actions
  localparam logic ACT_LOAD_B = 1'b0;
  localparam logic ACT_A_ELEM = 1'b1;

endpackage

`default_nettype wire

### rtl/core/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/matrix_multiply_engine_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top: streamed A times stored B, one shared mac unit
// a B item or an A item that does not end a row is taken without a stall;
//   an item that ends a row holds the input off until each output column
//   has been computed in turn and its result registered for output
// throughput: one item per cycle between row ends; stalled results lengthen row ends
// reset: synchronous rst_n clears control state; B and row stores hold garbage
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine_top #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input items
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_action,
  input  wire logic signed [mme_pkg::ELEM_W-1:0]    in_element_value,
  // result items
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [mme_pkg::ACC_W-1:0]     out_result_value,
  output logic                                      out_last_in_row,
  output logic                                      out_last_in_matrix,
  output logic                                      out_last_in_batch,
  // configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [mme_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(MAX_DIM);
  localparam int BDEPTH = MAX_DIM * MAX_DIM;
  localparam int BW     = $clog2(BDEPTH);
  localparam int DW     = $clog2(MAX_DIM + 1);
  localparam int CMPW   = (DW > mme_pkg::CFG_DIM_W) ? DW : mme_pkg::CFG_DIM_W;
  localparam int TW     = 2 * DW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // configuration registers
  logic [mme_pkg::CFG_DIM_W-1:0] inner_dim_r, inner_dim_nxt;
  logic [mme_pkg::CFG_DIM_W-1:0] out_cols_r, out_cols_nxt;
  logic [mme_pkg::CFG_CNT_W-1:0] rows_r, rows_nxt;
  logic [mme_pkg::CFG_CNT_W-1:0] mats_r, mats_nxt;

  // position state
  logic [BW-1:0]             b_idx_r, b_idx_nxt;
  logic [AW-1:0]             a_col_r, a_col_nxt;
  logic [mme_pkg::CNT_W-1:0] row_r, row_nxt;
  logic [mme_pkg::CNT_W-1:0] mat_r, mat_nxt;

  // sequencer
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] kk_r, kk_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [BW-1:0] b_addr_r, b_addr_nxt;
  logic          end_mat_r, end_mat_nxt;
  logic          end_batch_r, end_batch_nxt;

  // mac pipeline
  logic                                 rd_v_r, rd_v_nxt;
  logic                                 rd_first_r, rd_first_nxt;
  logic                                 rd_last_r, rd_last_nxt;
  logic signed [mme_pkg::PROD_W-1:0]    prod_r;
  logic                                 prod_v_r, prod_first_r, prod_last_r;
  logic signed [mme_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic                                 done_r, done_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic signed [mme_pkg::ACC_W-1:0] out_value_r;
  logic                             out_row_r, out_mat_r, out_batch_r;

  // clamped dimensions
  logic [CMPW-1:0]           kd_ext, nd_ext;
  logic [DW-1:0]             kd, nd;
  logic [TW-1:0]             total;
  logic [AW-1:0]             kd_last, nd_last;
  logic [BW-1:0]             b_last;
  logic [mme_pkg::CNT_W-1:0] rows_last, mats_last;

  logic signed [mme_pkg::ELEM_W-1:0] a_rdata, b_rdata;

  logic in_acc, cfg_we, a_we, b_we, row_done, rd_en, out_free, emit;
  logic row_end_mat, row_end_batch;

  assign kd_ext = CMPW'(inner_dim_r);
  assign nd_ext = CMPW'(out_cols_r);

  always_comb begin
    priority if (kd_ext == '0) begin
      kd = DW'(1);
    end else if (kd_ext > CMPW'(MAX_DIM)) begin
      kd = DW'(MAX_DIM);
    end else begin
      kd = DW'(kd_ext);
    end
    priority if (nd_ext == '0) begin
      nd = DW'(1);
    end else if (nd_ext > CMPW'(MAX_DIM)) begin
      nd = DW'(MAX_DIM);
    end else begin
      nd = DW'(nd_ext);
    end
    priority if (rows_r == '0) begin
      rows_last = '0;
    end else if (rows_r > mme_pkg::CFG_CNT_W'(mme_pkg::MAX_COUNT)) begin
      rows_last = mme_pkg::CNT_W'(mme_pkg::MAX_COUNT - 1);
    end else begin
      rows_last = mme_pkg::CNT_W'(rows_r - 1'b1);
    end
    priority if (mats_r == '0) begin
      mats_last = '0;
    end else if (mats_r > mme_pkg::CFG_CNT_W'(mme_pkg::MAX_COUNT)) begin
      mats_last = mme_pkg::CNT_W'(mme_pkg::MAX_COUNT - 1);
    end else begin
      mats_last = mme_pkg::CNT_W'(mats_r - 1'b1);
    end
  end

  assign total   = TW'(kd) * TW'(nd);
  assign b_last  = BW'(total - TW'(1));
  assign kd_last = AW'(kd - DW'(1));
  assign nd_last = AW'(nd - DW'(1));

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign a_we      = in_acc && (in_action == mme_pkg::ACT_A_ELEM);
  assign b_we      = in_acc && (in_action == mme_pkg::ACT_LOAD_B);
  assign row_done  = a_we && (a_col_r == kd_last);
  assign rd_en     = (state_r == ST_RUN);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == ST_DRAIN) && done_r && out_free;

  assign row_end_mat   = (row_r == rows_last);
  assign row_end_batch = row_end_mat && (mat_r == mats_last);

  mme_ram #(
    .WIDTH (mme_pkg::ELEM_W),
    .DEPTH (MAX_DIM)
  ) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_col_r),
    .wdata (in_element_value),
    .re    (rd_en),
    .raddr (kk_r),
    .rdata (a_rdata)
  );

  mme_ram #(
    .WIDTH (mme_pkg::ELEM_W),
    .DEPTH (BDEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_idx_r),
    .wdata (in_element_value),
    .re    (rd_en),
    .raddr (b_addr_r),
    .rdata (b_rdata)
  );

  // configuration and stream positions
  always_comb begin
    inner_dim_nxt = inner_dim_r;
    out_cols_nxt  = out_cols_r;
    rows_nxt      = rows_r;
    mats_nxt      = mats_r;
    b_idx_nxt     = b_idx_r;
    a_col_nxt     = a_col_r;
    row_nxt       = row_r;
    mat_nxt       = mat_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mme_pkg::REG_INNER_DIM:       inner_dim_nxt = mme_pkg::CFG_DIM_W'(cfg_data);
        mme_pkg::REG_OUT_COLS:        out_cols_nxt  = mme_pkg::CFG_DIM_W'(cfg_data);
        mme_pkg::REG_ROWS_PER_MATRIX: rows_nxt      = mme_pkg::CFG_CNT_W'(cfg_data);
        mme_pkg::REG_BATCH_COUNT:     mats_nxt      = mme_pkg::CFG_CNT_W'(cfg_data);
      endcase
      b_idx_nxt = '0;
      a_col_nxt = '0;
      row_nxt   = '0;
      mat_nxt   = '0;
    end
    if (b_we) begin
      b_idx_nxt = (b_idx_r == b_last) ? '0 : b_idx_r + 1'b1;
    end
    if (a_we) begin
      a_col_nxt = row_done ? '0 : a_col_r + 1'b1;
    end
    if (row_done) begin
      if (row_end_mat) begin
        row_nxt = '0;
        mat_nxt = row_end_batch ? '0 : mat_r + 1'b1;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  // sequencer: one column of the row at a time through the shared mac
  always_comb begin
    state_nxt     = state_r;
    kk_nxt        = kk_r;
    j_nxt         = j_r;
    b_addr_nxt    = b_addr_r;
    end_mat_nxt   = end_mat_r;
    end_batch_nxt = end_batch_r;
    rd_v_nxt      = 1'b0;
    rd_first_nxt  = 1'b0;
    rd_last_nxt   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (row_done) begin
          state_nxt     = ST_RUN;
          kk_nxt        = '0;
          j_nxt         = '0;
          b_addr_nxt    = '0;
          end_mat_nxt   = row_end_mat;
          end_batch_nxt = row_end_batch;
        end
      end
      ST_RUN: begin
        rd_v_nxt     = 1'b1;
        rd_first_nxt = (kk_r == '0);
        rd_last_nxt  = (kk_r == kd_last);
        // step down the column of B
        b_addr_nxt   = b_addr_r + BW'(nd);
        kk_nxt       = kk_r + 1'b1;
        if (kk_r == kd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (emit) begin
          if (j_r == nd_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt  = ST_RUN;
            kk_nxt     = '0;
            j_nxt      = j_r + 1'b1;
            b_addr_nxt = BW'(j_r + 1'b1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    if (prod_v_r) begin
      acc_nxt = prod_first_r ? mme_pkg::ACC_W'(prod_r)
                             : acc_r + mme_pkg::ACC_W'(prod_r);
    end
    done_nxt = done_r;
    if (emit) begin
      done_nxt = 1'b0;
    end else if (prod_v_r && prod_last_r) begin
      done_nxt = 1'b1;
    end
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_dim_r  <= mme_pkg::RST_INNER_DIM;
      out_cols_r   <= mme_pkg::RST_OUT_COLS;
      rows_r       <= mme_pkg::RST_ROWS_PER_MATRIX;
      mats_r       <= mme_pkg::RST_BATCH_COUNT;
      b_idx_r      <= '0;
      a_col_r      <= '0;
      row_r        <= '0;
      mat_r        <= '0;
      state_r      <= ST_IDLE;
      kk_r         <= '0;
      j_r          <= '0;
      b_addr_r     <= '0;
      end_mat_r    <= 1'b0;
      end_batch_r  <= 1'b0;
      rd_v_r       <= 1'b0;
      rd_first_r   <= 1'b0;
      rd_last_r    <= 1'b0;
      prod_v_r     <= 1'b0;
      prod_first_r <= 1'b0;
      prod_last_r  <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      inner_dim_r  <= inner_dim_nxt;
      out_cols_r   <= out_cols_nxt;
      rows_r       <= rows_nxt;
      mats_r       <= mats_nxt;
      b_idx_r      <= b_idx_nxt;
      a_col_r      <= a_col_nxt;
      row_r        <= row_nxt;
      mat_r        <= mat_nxt;
      state_r      <= state_nxt;
      kk_r         <= kk_nxt;
      j_r          <= j_nxt;
      b_addr_r     <= b_addr_nxt;
      end_mat_r    <= end_mat_nxt;
      end_batch_r  <= end_batch_nxt;
      rd_v_r       <= rd_v_nxt;
      rd_first_r   <= rd_first_nxt;
      rd_last_r    <= rd_last_nxt;
      prod_v_r     <= rd_v_r;
      prod_first_r <= rd_first_r;
      prod_last_r  <= rd_last_r;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= a_rdata * b_rdata;
    acc_r  <= acc_nxt;
    if (emit) begin
      out_value_r <= acc_r;
      out_row_r   <= (j_r == nd_last);
      out_mat_r   <= (j_r == nd_last) && end_mat_r;
      out_batch_r <= (j_r == nd_last) && end_batch_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_value_r;
  assign out_last_in_row    = out_row_r;
  assign out_last_in_matrix = out_mat_r;
  assign out_last_in_batch  = out_batch_r;

endmodule

`default_nettype wire

### rtl/core/mme_checker.sv
// ----------------------------------------------------------------------------
// mme_checker: port-level checks for the matrix multiply engine
// watches handshakes and result flags, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mme_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              in_action,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [mme_pkg::ACC_W-1:0]         out_result_value,
  input wire logic                              out_last_in_row,
  input wire logic                              out_last_in_matrix,
  input wire logic                              out_last_in_batch,
  input wire logic                              cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value))
    else $error("stalled result item changed");

  // batch end implies matrix end implies row end
  a_flag_nest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_last_in_batch || out_last_in_matrix) &&
                  (!out_last_in_matrix || out_last_in_row))
    else $error("result end flags not nested");

  // loading B never starts a computation
  a_b_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == mme_pkg::ACT_LOAD_B) |=> !in_stall)
    else $error("B load made the engine busy");

  // configuration is open exactly when items are
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == !in_stall)
    else $error("config ready disagrees with input stall");

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_action          (in_action),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_result_value   (out_result_value),
  .out_last_in_row    (out_last_in_row),
  .out_last_in_matrix (out_last_in_matrix),
  .out_last_in_batch  (out_last_in_batch),
  .cfg_ready          (cfg_ready)
);

`default_nettype wire

### verif/tb_matrix_multiply_engine_top.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine_top: self-checking bench for the matrix engine
// Drives register writes, B loads and A rows under random idle and stall, predicts every dot
// product with flags from a local model of the block, and checks each result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix_multiply_engine_top;
  import mme_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 350;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEM_TARGET   = 105;
  localparam int NUM_DIRECTED  = 22;
  localparam int B_DEPTH       = MAX_DIM_DEF * MAX_DIM_DEF;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic                    row_end;
    logic                    mat_end;
    logic                    batch_end;
  } dot_result_t;

  typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_t;

  typedef struct packed {
    step_kind_t                kind;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [CFG_DATA_W-1:0]     reg_data;
    logic                      action;
    logic signed [ELEM_W-1:0]  elem;
    logic                      typed;
    dot_result_t               want;
  } directed_step_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_action;
  logic signed [ELEM_W-1:0] in_element_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [ACC_W-1:0]  out_result_value;
  logic                     out_last_in_row;
  logic                     out_last_in_matrix;
  logic                     out_last_in_batch;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  // predictor state
  logic [CFG_DIM_W-1:0]     inner_reg;
  logic [CFG_DIM_W-1:0]     cols_reg;
  logic [CFG_CNT_W-1:0]     rows_reg;
  logic [CFG_CNT_W-1:0]     batch_reg;
  logic signed [ELEM_W-1:0] b_matrix [B_DEPTH];
  logic signed [ELEM_W-1:0] a_row [MAX_DIM_DEF];
  int                       b_pos;
  int                       a_pos;
  int                       row_pos;
  int                       mat_pos;

  dot_result_t pending_dots[$];
  dot_result_t head_dot;
  int          fail_count;
  int          items_sent;
  int          cycle_count;
  int          phase_no;
  bit          hold_req;

  // stimulus table: cfg rows and items interleaved; expected values typed where obvious
  directed_step_t directed_steps [NUM_DIRECTED] = '{
    '{STEP_CFG,  REG_INNER_DIM,       13'd1, ACT_LOAD_B, 16'sd0, 1'b0, '0},
    '{STEP_CFG,  REG_OUT_COLS,        13'd1, ACT_LOAD_B, 16'sd0, 1'b0, '0},
    '{STEP_CFG,  REG_ROWS_PER_MATRIX, 13'd2, ACT_LOAD_B, 16'sd0, 1'b0, '0},
    '{STEP_CFG,  REG_BATCH_COUNT,     13'd2, ACT_LOAD_B, 16'sd0, 1'b0, '0},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_LOAD_B, 16'sh7FFF, 1'b0, '0},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'sh8000, 1'b1,
      '{-40'sd1073709056, 1'b1, 1'b0, 1'b0}},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'sh7FFF, 1'b1,
      '{40'sd1073676289, 1'b1, 1'b1, 1'b0}},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'shFFFF, 1'b1,
      '{-40'sd32767, 1'b1, 1'b0, 1'b0}},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'sd1, 1'b1,
      '{40'sd32767, 1'b1, 1'b1, 1'b1}},
    // B store wraps and overwrites its only entry
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_LOAD_B, 16'sh8000, 1'b0, '0},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'sh8000, 1'b1,
      '{40'sd1073741824, 1'b1, 1'b0, 1'b0}},
    '{STEP_CFG,  REG_INNER_DIM,       13'd2, ACT_LOAD_B, 16'sd0, 1'b0, '0},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_LOAD_B, 16'sh8000, 1'b0, '0},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_LOAD_B, 16'sh8000, 1'b0, '0},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'sh8000, 1'b0, '0},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'sh8000, 1'b1,
      '{40'sd2147483648, 1'b1, 1'b0, 1'b0}},
    // B load in the middle of a row, used when the row completes
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'sd3, 1'b0, '0},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_LOAD_B, 16'sd7, 1'b0, '0},
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'shFFFE, 1'b1,
      '{40'sd65557, 1'b1, 1'b1, 1'b0}},
    // partial row dropped by the next register write
    '{STEP_ITEM, REG_INNER_DIM, 13'd0, ACT_A_ELEM, 16'sd1, 1'b0, '0},
    '{STEP_CFG,  REG_ROWS_PER_MATRIX, 13'd0, ACT_LOAD_B, 16'sd0, 1'b0, '0},
    '{STEP_CFG,  REG_BATCH_COUNT,     13'h1FFF, ACT_LOAD_B, 16'sd0, 1'b0, '0}
  };

  matrix_multiply_engine_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_element_value   (in_element_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_value   (out_result_value),
    .out_last_in_row    (out_last_in_row),
    .out_last_in_matrix (out_last_in_matrix),
    .out_last_in_batch  (out_last_in_batch),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_cfg(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'shFFFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim(bit only_small);
    logic [CFG_DIM_W-1:0] d;
    d = CFG_DIM_W'($urandom_range(1, 4));
    if (!only_small) begin
      case ($urandom_range(0, 7))
        0: d = '0;
        1: d = 5'd16;
        2: d = CFG_DIM_W'($urandom_range(17, 31));
        default: d = CFG_DIM_W'($urandom_range(1, 4));
      endcase
    end
    // upper data bits are ignored by the dimension registers
    return {8'($urandom), d};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 13'h1FFF;
      2: return 13'd4096;
      default: return CFG_DATA_W'($urandom_range(1, 4));
    endcase
  endfunction

  // works out the dot products that one accepted item causes
  task automatic predict_item(input logic act, input logic signed [ELEM_W-1:0] v);
    int          kd;
    int          nd;
    int          rows;
    int          mats;
    int          j;
    int          k;
    bit          end_mat;
    bit          end_batch;
    longint      acc;
    dot_result_t r;
    kd   = clamp_cfg(int'(inner_reg), MAX_DIM_DEF);
    nd   = clamp_cfg(int'(cols_reg), MAX_DIM_DEF);
    rows = clamp_cfg(int'(rows_reg), MAX_COUNT);
    mats = clamp_cfg(int'(batch_reg), MAX_COUNT);
    if (act == ACT_LOAD_B) begin
      if (b_pos >= kd * nd) b_pos = 0;
      b_matrix[b_pos] = v;
      b_pos++;
      if (b_pos >= kd * nd) b_pos = 0;
      return;
    end
    if (a_pos >= kd) a_pos = 0;
    a_row[a_pos] = v;
    a_pos++;
    if (a_pos < kd) return;
    a_pos = 0;
    if (row_pos >= rows) row_pos = 0;
    if (mat_pos >= mats) mat_pos = 0;
    end_mat   = (row_pos == rows - 1);
    end_batch = end_mat && (mat_pos == mats - 1);
    for (j = 0; j < nd; j++) begin
      acc = 0;
      for (k = 0; k < kd; k++) begin
        acc += longint'(a_row[k]) * longint'(b_matrix[k * nd + j]);
      end
      r.value     = acc[ACC_W-1:0];
      r.row_end   = (j == nd - 1);
      r.mat_end   = (j == nd - 1) && end_mat;
      r.batch_end = (j == nd - 1) && end_batch;
      pending_dots.push_back(r);
    end
    if (end_mat) begin
      row_pos = 0;
      mat_pos = end_batch ? 0 : mat_pos + 1;
    end else begin
      row_pos++;
    end
  endtask

  task automatic send_item(input logic act, input logic signed [ELEM_W-1:0] v, input bit quiet);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0 && in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
      gap--;
    end
    repeat (gap) @(negedge clk);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_action        <= act;
    in_element_value <= v;
    do @(posedge clk); while (in_stall);
    predict_item(act, v);
    items_sent++;
  endtask

  // block is idle once every dot product is out and the settle time has passed
  task automatic wait_idle();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INNER_DIM:       inner_reg = data[CFG_DIM_W-1:0];
      REG_OUT_COLS:        cols_reg  = data[CFG_DIM_W-1:0];
      REG_ROWS_PER_MATRIX: rows_reg  = data[CFG_CNT_W-1:0];
      REG_BATCH_COUNT:     batch_reg = data[CFG_CNT_W-1:0];
      default: ;
    endcase
    b_pos   = 0;
    a_pos   = 0;
    row_pos = 0;
    mat_pos = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one setting: registers, a full B load, then A rows with stray B loads
  task automatic run_phase(input bit big, input bit write_all);
    int kd;
    int nd;
    int n_elems;
    int k;
    bit quiet;
    wait_idle();
    if (big) begin
      cfg_write(REG_INNER_DIM, {8'($urandom), 5'd16});
      cfg_write(REG_OUT_COLS, {8'($urandom), 5'd2});
    end else begin
      if (write_all || $urandom_range(0, 1)) cfg_write(REG_INNER_DIM, pick_dim(1'b0));
      kd = clamp_cfg(int'(inner_reg), MAX_DIM_DEF);
      if (write_all || $urandom_range(0, 1) ||
          (kd > 4 && clamp_cfg(int'(cols_reg), MAX_DIM_DEF) > 4))
        cfg_write(REG_OUT_COLS, pick_dim(kd > 4));
      if (write_all || $urandom_range(0, 1)) cfg_write(REG_ROWS_PER_MATRIX, pick_count());
      if (write_all || $urandom_range(0, 1)) cfg_write(REG_BATCH_COUNT, pick_count());
    end
    kd    = clamp_cfg(int'(inner_reg), MAX_DIM_DEF);
    nd    = clamp_cfg(int'(cols_reg), MAX_DIM_DEF);
    quiet = ($urandom_range(0, 3) == 0);
    repeat (kd * nd) send_item(ACT_LOAD_B, rand_elem(), quiet);
    n_elems = (big ? 2 : $urandom_range(1, 4)) * kd;
    if ($urandom_range(0, 2) == 0) n_elems += $urandom_range(0, kd - 1);
    if (big) hold_req = 1'b1;
    for (k = 0; k < n_elems; k++) begin
      if ($urandom_range(0, 7) == 0) send_item(ACT_LOAD_B, rand_elem(), quiet);
      send_item(ACT_A_ELEM, rand_elem(), quiet);
    end
  endtask

  task automatic report_field(input string field, input longint want, input longint got);
    fail_count++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dots.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual %0d", $time,
                 longint'(out_result_value));
      end else begin
        head_dot = pending_dots.pop_front();
        if (out_result_value !== head_dot.value)
          report_field("result_value", longint'(head_dot.value), longint'(out_result_value));
        if (out_last_in_row !== head_dot.row_end)
          report_field("last_in_row", longint'(head_dot.row_end), longint'(out_last_in_row));
        if (out_last_in_matrix !== head_dot.mat_end)
          report_field("last_in_matrix", longint'(head_dot.mat_end),
                       longint'(out_last_in_matrix));
        if (out_last_in_batch !== head_dot.batch_end)
          report_field("last_in_batch", longint'(head_dot.batch_end),
                       longint'(out_last_in_batch));
      end
    end
  end

  // result side stall, with one long hold-off while the sender keeps going
  initial begin : stall_gen
    int stall_run;
    int free_run;
    bit hold_done;
    out_stall = 1'b0;
    stall_run = 0;
    free_run  = 0;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_run = HOLD_CYCLES;
      end else if (stall_run == 0 && free_run == 0) begin
        stall_run = idle_len();
        free_run  = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(0, 12);
      end
      if (stall_run != 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        if (free_run != 0) free_run--;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main_seq
    int i;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_action        = ACT_LOAD_B;
    in_element_value = '0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_INNER_DIM;
    cfg_data         = '0;
    inner_reg        = RST_INNER_DIM;
    cols_reg         = RST_OUT_COLS;
    rows_reg         = RST_ROWS_PER_MATRIX;
    batch_reg        = RST_BATCH_COUNT;
    b_pos            = 0;
    a_pos            = 0;
    row_pos          = 0;
    mat_pos          = 0;
    fail_count       = 0;
    items_sent       = 0;
    hold_req         = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_steps[i].kind == STEP_CFG) begin
        wait_idle();
        cfg_write(directed_steps[i].reg_idx, directed_steps[i].reg_data);
      end else begin
        send_item(directed_steps[i].action, directed_steps[i].elem, 1'b0);
        if (directed_steps[i].typed) begin
          void'(pending_dots.pop_back());
          pending_dots.push_back(directed_steps[i].want);
        end
      end
    end

    // the first phase always runs and carries the long result hold-off
    phase_no = 0;
    while (phase_no == 0 || items_sent < ITEM_TARGET) begin
      run_phase(phase_no == 0, phase_no == 1);
      phase_no++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_dots.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
